@@ sv/q2e_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, stage counts, CORDIC angle table and cell data types.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int CORDIC_STAGES  = 16;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int NCELLS = (CORDIC_STAGES < ATAN_TABLE_LEN) ? CORDIC_STAGES : ATAN_TABLE_LEN;

  localparam int CW       = 36;   // CORDIC x/y datapath width
  localparam int SQW      = 58;   // square-root remainder/root width
  localparam int SQ_CELLS = 29;   // one cell per result bit, 2^28 down to 2^0
  localparam int SQ_TOP   = 56;

  // valid line: product, combine, square, sqrt cells, pre-rotation, CORDIC cells
  localparam int LAT = 3 + SQ_CELLS + 1 + NCELLS;

  localparam logic [28:0] THRESH_RESET = 29'd133955584;
  localparam logic [31:0] ANGLE_PI     = 32'h8000_0000;
  localparam logic signed [15:0] PITCH_MAX = 16'sd16384;
  localparam logic signed [15:0] PITCH_MIN = -16'sd16384;
  localparam logic signed [33:0] ONE_Q28   = 34'sd268435456;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic        [31:0]   z;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic [SQW-1:0] v;
    logic [SQW-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0] roll_y;
    logic signed [CW-1:0] roll_x;
    logic signed [CW-1:0] yaw_y;
    logic signed [CW-1:0] yaw_x;
    logic signed [29:0]   s;
    logic                 sing;
    logic                 tpos;
  } side_t;

  typedef struct packed {
    logic sing;
    logic tpos;
  } flag_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] round16(input logic [31:0] a);
    logic [31:0] s;
    s = a + 32'h0000_8000;
    return s[31:16];
  endfunction

endpackage

@@ sv/q2e_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module q2e_cordic_cell (
  input  logic               clk,
  input  logic               en,
  input  logic [4:0]         shift,
  input  q2e_pkg::cordic_t   din,
  output q2e_pkg::cordic_t   dout
);

  logic signed [q2e_pkg::CW-1:0] dx;
  logic signed [q2e_pkg::CW-1:0] dy;
  logic [31:0] ang;

  assign dx  = din.y >>> shift;
  assign dy  = din.x >>> shift;
  assign ang = q2e_pkg::atan_bam(shift);

  always_ff @(posedge clk) begin
    if (en) begin
      dout.zero <= din.zero;
      if (!din.y[q2e_pkg::CW-1]) begin
        dout.x <= din.x + dx;
        dout.y <= din.y - dy;
        dout.z <= din.z + ang;
      end else begin
        dout.x <= din.x - dx;
        dout.y <= din.y + dy;
        dout.z <= din.z - ang;
      end
    end
  end

endmodule

@@ sv/q2e_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One restoring square-root step at a fixed bit position, registered.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell (
  input  logic             clk,
  input  logic             en,
  input  logic [5:0]       bitpos,
  input  q2e_pkg::sqrt_t   din,
  output q2e_pkg::sqrt_t   dout
);

  logic [q2e_pkg::SQW-1:0] bval;
  logic [q2e_pkg::SQW-1:0] trial;

  assign bval  = q2e_pkg::SQW'(1) << bitpos;
  assign trial = din.res + bval;

  always_ff @(posedge clk) begin
    if (en) begin
      if (din.v >= trial) begin
        dout.v   <= din.v - trial;
        dout.res <= (din.res >> 1) + bval;
      end else begin
        dout.v   <= din.v;
        dout.res <= din.res >> 1;
      end
    end
  end

endmodule

@@ sv/quaternion_to_euler_zyx.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_zyx
// Q1.14 quaternion to Z-Y-X Euler binary angles with gimbal-lock handling.
//
// Input channel s_*: one quaternion item per handshake, tdata = w, x, y, z.
// Output channel m_*: roll, pitch, yaw in tdata, singular flag in tuser.
// cfg_wr_en / cfg_wr_data load the gimbal threshold (Q1.28, unsigned).
// Throughput: one item per cycle unless the receiver stalls. Stages from accept
// to m_tvalid: products, combine, square, 29 square-root cells, pre-rotation,
// 16 CORDIC cells, output register; the square-root chain sets the depth.
// Roll, yaw and pitch each run through their own row of CORDIC cells.
// The whole pipeline advances when the output register is empty or taken;
// while the receiver stalls, every stage holds and s_tready is low.
// Reset clears all valid bits and loads the default threshold; no item is
// lost or repeated across a stall.
// ----------------------------------------------------------------------------
module quaternion_to_euler_zyx (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [28:0] cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // q_w, q_x, q_y, q_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic [0:0]  m_tuser    // singular_flag
);

  localparam int CW = q2e_pkg::CW;
  localparam int NC = q2e_pkg::NCELLS;
  localparam int SC = q2e_pkg::SQ_CELLS;

  logic [28:0] thr;
  logic        adv;
  logic [q2e_pkg::LAT-1:0] vld;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= q2e_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[q2e_pkg::LAT-2:0], s_tvalid};
    end
  end

  // products
  logic signed [15:0] iw, ix, iy, iz;
  logic signed [31:0] p_wy, p_xz, p_yz, p_wx, p_ww, p_xx, p_yy, p_zz, p_xy, p_wz;
  logic signed [15:0] a_x, a_w;

  assign iw = s_tdata[15:0];
  assign ix = s_tdata[31:16];
  assign iy = s_tdata[47:32];
  assign iz = s_tdata[63:48];

  always_ff @(posedge clk) begin
    if (adv) begin
      p_wy <= iw * iy;  p_xz <= ix * iz;
      p_yz <= iy * iz;  p_wx <= iw * ix;
      p_ww <= iw * iw;  p_xx <= ix * ix;
      p_yy <= iy * iy;  p_zz <= iz * iz;
      p_xy <= ix * iy;  p_wz <= iw * iz;
      a_x  <= ix;
      a_w  <= iw;
    end
  end

  // combine
  logic signed [33:0] t, s2, s_cl;
  logic signed [CW-1:0] ry, rx, yy, yx;
  logic signed [33:0] thr_s;
  logic sing_c;
  q2e_pkg::side_t side_b;
  logic [28:0] s_abs_b;

  always_comb begin
    t     = 34'(p_wy) - 34'(p_xz);
    thr_s = $signed({5'b0, thr});
    sing_c = (t > thr_s) || (t < -thr_s);
    s2 = t <<< 1;
    if (s2 > q2e_pkg::ONE_Q28) begin
      s_cl = q2e_pkg::ONE_Q28;
    end else if (s2 < -q2e_pkg::ONE_Q28) begin
      s_cl = -q2e_pkg::ONE_Q28;
    end else begin
      s_cl = s2;
    end
    ry = (CW'(p_yz) + CW'(p_wx)) <<< 1;
    rx = CW'(p_ww) - CW'(p_xx) - CW'(p_yy) + CW'(p_zz);
    yy = (CW'(p_xy) + CW'(p_wz)) <<< 1;
    yx = CW'(p_ww) + CW'(p_xx) - CW'(p_yy) - CW'(p_zz);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_b.roll_y <= ry;
      side_b.roll_x <= rx;
      side_b.yaw_y  <= sing_c ? CW'(a_x) : yy;
      side_b.yaw_x  <= sing_c ? CW'(a_w) : yx;
      side_b.s      <= s_cl[29:0];
      side_b.sing   <= sing_c;
      side_b.tpos   <= !t[33] && (t != '0);
      s_abs_b       <= s_cl[33] ? 29'(-s_cl) : s_cl[28:0];
    end
  end

  // square and square-root row
  logic [57:0] sq;
  q2e_pkg::sqrt_t sq_q [SC+1];
  q2e_pkg::side_t side_q [SC+1];

  assign sq = s_abs_b * s_abs_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_q[0].v   <= (q2e_pkg::SQW'(1) << q2e_pkg::SQ_TOP) - sq;
      sq_q[0].res <= '0;
      side_q[0]   <= side_b;
    end
  end

  for (genvar k = 0; k < SC; k++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk    (clk),
      .en     (adv),
      .bitpos (6'(q2e_pkg::SQ_TOP - 2 * k)),
      .din    (sq_q[k]),
      .dout   (sq_q[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // pre-rotation into three CORDIC rows: roll, pitch, yaw
  q2e_pkg::cordic_t lane [3][NC+1];
  q2e_pkg::flag_t   flg [NC+1];
  logic signed [CW-1:0] pre_y [3];
  logic signed [CW-1:0] pre_x [3];

  always_comb begin
    pre_y[0] = side_q[SC].roll_y;
    pre_x[0] = side_q[SC].roll_x;
    pre_y[1] = CW'(side_q[SC].s);
    pre_x[1] = $signed(sq_q[SC].res[CW-1:0]);
    pre_y[2] = side_q[SC].yaw_y;
    pre_x[2] = side_q[SC].yaw_x;
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (adv) begin
        lane[l][0].zero <= (pre_x[l] == '0) && (pre_y[l] == '0);
        if (pre_x[l][CW-1]) begin
          lane[l][0].x <= -pre_x[l];
          lane[l][0].y <= -pre_y[l];
          lane[l][0].z <= q2e_pkg::ANGLE_PI;
        end else begin
          lane[l][0].x <= pre_x[l];
          lane[l][0].y <= pre_y[l];
          lane[l][0].z <= '0;
        end
      end
    end
    for (genvar i = 0; i < NC; i++) begin : g_cell
      q2e_cordic_cell u_cell (
        .clk   (clk),
        .en    (adv),
        .shift (5'(i)),
        .din   (lane[l][i]),
        .dout  (lane[l][i+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flg[0].sing <= side_q[SC].sing;
      flg[0].tpos <= side_q[SC].tpos;
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_flag
    always_ff @(posedge clk) begin
      if (adv) begin
        flg[i+1] <= flg[i];
      end
    end
  end

  // finish
  logic [31:0] a_roll, a_pitch, a_yaw, yaw_s;
  logic signed [15:0] p_r, p_out, roll_out, yaw_out;

  always_comb begin
    a_roll  = lane[0][NC].zero ? 32'h0 : lane[0][NC].z;
    a_pitch = lane[1][NC].zero ? 32'h0 : lane[1][NC].z;
    a_yaw   = lane[2][NC].zero ? 32'h0 : lane[2][NC].z;
    yaw_s   = flg[NC].tpos ? (32'h0 - (a_yaw << 1)) : (a_yaw << 1);
    p_r     = $signed(q2e_pkg::round16(a_pitch));
    if (flg[NC].sing) begin
      roll_out = '0;
      p_out    = flg[NC].tpos ? q2e_pkg::PITCH_MAX : q2e_pkg::PITCH_MIN;
      yaw_out  = $signed(q2e_pkg::round16(yaw_s));
    end else begin
      roll_out = $signed(q2e_pkg::round16(a_roll));
      if (p_r > q2e_pkg::PITCH_MAX) begin
        p_out = q2e_pkg::PITCH_MAX;
      end else if (p_r < q2e_pkg::PITCH_MIN) begin
        p_out = q2e_pkg::PITCH_MIN;
      end else begin
        p_out = p_r;
      end
      yaw_out = $signed(q2e_pkg::round16(a_yaw));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vld[q2e_pkg::LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {yaw_out, p_out, roll_out};
      m_tuser <= flg[NC].sing;
    end
  end

endmodule

@@ sv/q2e_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_checker
// Port-level checks on the result channel of the Euler converter.
// ----------------------------------------------------------------------------
module q2e_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [0:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_sing_roll: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[15:0] == 16'h0)
    else $error("singular item with nonzero roll");

  a_sing_pitch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[31:16] == 16'h4000 || m_tdata[31:16] == 16'hC000)
    else $error("singular item pitch not at a pole");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[31:16]) <= 16384 && $signed(m_tdata[31:16]) >= -16384)
    else $error("pitch out of range");

endmodule

bind quaternion_to_euler_zyx q2e_checker u_q2e_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
